>>> rtl/core/qej_pkg.sv
// qej_pkg: shared types and constants of the quad element jacobian engine
// no dependencies; used by qej_div and quad_element_jacobian_top, not by qej_ram
package qej_pkg;

  localparam int TABLE_ROWS = 16;
  localparam int ROW_BITS   = 4;
  localparam int DERIV_BITS = 18;
  localparam int FRAC_BITS  = 16;
  localparam int ROW_WIDTH  = 8 * DERIV_BITS;
  localparam int DIV_STEPS  = 32 + FRAC_BITS;
  localparam int STEP_BITS  = 6;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ELEMENT = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [3:0]        point_index;
    logic signed [31:0] a_value_0;
    logic signed [31:0] a_value_1;
    logic signed [31:0] a_value_2;
    logic signed [31:0] a_value_3;
    logic signed [31:0] b_value_0;
    logic signed [31:0] b_value_1;
    logic signed [31:0] b_value_2;
    logic signed [31:0] b_value_3;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] jac_00;
    logic signed [31:0] jac_01;
    logic signed [31:0] jac_10;
    logic signed [31:0] jac_11;
    logic signed [31:0] determinant;
    logic signed [31:0] inv_00;
    logic signed [31:0] inv_01;
    logic signed [31:0] inv_10;
    logic signed [31:0] inv_11;
    logic [3:0]         result_point;
    logic               last_point;
    logic               singular;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_ROUND,
    ST_DMUL,
    ST_DSUB,
    ST_DIV,
    ST_OUT
  } seq_state_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/qej_ram.sv
// qej_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
module qej_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/qej_div.sv
// qej_div: four-lane restoring divider, num * 2^16 / den rounded and saturated
// depends on qej_pkg; one quotient bit per lane per cycle
module qej_div
  import qej_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] den,
  input  logic signed [32:0] num [4],
  output logic signed [31:0] quo [4],
  output logic               done
);

  logic [31:0]          dmag;
  logic [31:0]          rem [4];
  logic [DIV_STEPS-1:0] dq [4];
  logic [3:0]           neg;
  logic [STEP_BITS-1:0] cnt;
  logic                 busy;
  logic                 fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_BITS'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [32:0] trial;
    logic [32:0] nabs;
    logic [33:0] twice;
    logic [DIV_STEPS:0] qr;

    assign trial = {rem[l], dq[l][DIV_STEPS-1]};
    assign nabs  = num[l][32] ? 33'(-num[l]) : 33'(num[l]);
    assign twice = {1'b0, rem[l], 1'b0};
    assign qr    = {1'b0, dq[l]} + ((twice >= {2'b00, dmag}) ? 1'b1 : 1'b0);

    always_ff @(posedge clk) begin
      if (start) begin
        rem[l] <= '0;
        dq[l]  <= {nabs[31:0], {FRAC_BITS{1'b0}}};
        neg[l] <= num[l][32] ^ den[31];
      end else if (busy) begin
        if (trial >= {1'b0, dmag}) begin
          rem[l] <= 32'(trial - {1'b0, dmag});
          dq[l]  <= {dq[l][DIV_STEPS-2:0], 1'b1};
        end else begin
          rem[l] <= trial[31:0];
          dq[l]  <= {dq[l][DIV_STEPS-2:0], 1'b0};
        end
      end
      if (fin) begin
        if (neg[l]) begin
          quo[l] <= (qr >= (DIV_STEPS+1)'(33'h080000000)) ? 32'sh80000000 : 32'(-qr);
        end else begin
          quo[l] <= (qr > (DIV_STEPS+1)'(33'h07fffffff)) ? 32'sh7fffffff : 32'(qr);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dmag <= den[31] ? 32'(-den) : 32'(den);
    end
  end

endmodule

>>> rtl/core/quad_element_jacobian_top.sv
// quad_element_jacobian_top: jacobian, determinant and inverse per integration point
// depends on qej_pkg, qej_ram, qej_div
// load word: written while idle, no result; element word: accepted, then for each point
// read, mac, round, determinant, divide and output; a singular point skips the divide
// one element at a time, a stall holds the output state; the 48-step divider dominates
// synchronous reset: points_per_side to 2, control idle; table contents undefined
module quad_element_jacobian_top
  import qej_pkg::*;
#(
  parameter int MAX_POINTS_PER_SIDE = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_write,
  input  logic [2:0] cfg_data
);

  seq_state_t state, state_next;

  logic [2:0] points_per_side;
  logic       in_acc;
  logic       elem_go;
  logic       load_go;

  // node coordinates of the current element
  logic signed [31:0] xs [4];
  logic signed [31:0] ys [4];

  logic [ROW_BITS-1:0] point;
  logic [ROW_BITS-1:0] last_idx;
  logic [1:0]          node;

  logic                 rd_en;
  logic [ROW_WIDTH-1:0] row;
  logic [ROW_WIDTH-1:0] load_row;

  logic signed [51:0] acc [4];
  logic signed [31:0] jac [4];
  logic signed [63:0] prod0;
  logic signed [63:0] prod1;
  logic signed [31:0] det;
  logic               singular;

  logic               div_start;
  logic               div_done;
  logic signed [32:0] div_num [4];
  logic signed [31:0] div_quo [4];

  // number of points: side clamped to 1..max, squared, capped at the table
  logic [3:0] side;
  logic [7:0] sq;
  logic [ROW_BITS-1:0] last_calc;

  always_comb begin
    if (points_per_side == 3'd0) begin
      side = 4'd1;
    end else if (int'(points_per_side) > MAX_POINTS_PER_SIDE) begin
      side = 4'(MAX_POINTS_PER_SIDE);
    end else begin
      side = {1'b0, points_per_side};
    end
    sq = 8'(side * side);
    last_calc = (sq > 8'(TABLE_ROWS)) ? ROW_BITS'(TABLE_ROWS - 1) : ROW_BITS'(sq - 8'd1);
  end

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_go  = in_acc && (in_word.opcode == OP_LOAD);
  assign elem_go  = in_acc && (in_word.opcode == OP_ELEMENT);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      points_per_side <= 3'd2;
    end else if (cfg_write) begin
      points_per_side <= cfg_data;
    end
  end

  // derivative row: four d/dksi then four d/deta, low 18 bits of each
  assign load_row = {in_word.b_value_3[DERIV_BITS-1:0], in_word.b_value_2[DERIV_BITS-1:0],
                     in_word.b_value_1[DERIV_BITS-1:0], in_word.b_value_0[DERIV_BITS-1:0],
                     in_word.a_value_3[DERIV_BITS-1:0], in_word.a_value_2[DERIV_BITS-1:0],
                     in_word.a_value_1[DERIV_BITS-1:0], in_word.a_value_0[DERIV_BITS-1:0]};

  qej_ram #(
    .WIDTH (ROW_WIDTH),
    .DEPTH (TABLE_ROWS)
  ) u_table (
    .clk   (clk),
    .we    (load_go),
    .waddr (in_word.point_index),
    .wdata (load_row),
    .re    (rd_en),
    .raddr (point),
    .rdata (row)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    div_start  = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (elem_go) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_MAC;
      end
      ST_MAC: begin
        if (node == 2'd3) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: state_next = ST_DMUL;
      ST_DMUL:  state_next = ST_DSUB;
      ST_DSUB:  state_next = ST_DIV;
      ST_DIV: begin
        // zero determinant skips the divider
        if (singular) begin
          state_next = ST_OUT;
        end else if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = (point == last_idx) ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // div_start stays low; div_kick starts the divider on the first cycle after the determinant lands
    if (state == ST_DSUB) begin
      div_start = 1'b0;
    end
  end

  // divider start pulse, on the first cycle of the divide state
  logic div_kick;
  always_ff @(posedge clk) begin
    if (rst) begin
      div_kick <= 1'b0;
    end else begin
      div_kick <= (state == ST_DSUB);
    end
  end

  // point and node counters
  always_ff @(posedge clk) begin
    if (rst) begin
      point <= '0;
      node  <= '0;
    end else begin
      if (elem_go) begin
        point <= '0;
      end else if (state == ST_OUT && !out_stall) begin
        point <= point + 1'b1;
      end
      if (state == ST_MAC) begin
        node <= node + 1'b1;
      end else begin
        node <= '0;
      end
    end
  end

  // element coordinates and point count
  always_ff @(posedge clk) begin
    if (elem_go) begin
      xs[0] <= in_word.a_value_0;
      xs[1] <= in_word.a_value_1;
      xs[2] <= in_word.a_value_2;
      xs[3] <= in_word.a_value_3;
      ys[0] <= in_word.b_value_0;
      ys[1] <= in_word.b_value_1;
      ys[2] <= in_word.b_value_2;
      ys[3] <= in_word.b_value_3;
      last_idx <= last_calc;
    end
  end

  // one node per cycle into four accumulators
  logic signed [DERIV_BITS-1:0] dk;
  logic signed [DERIV_BITS-1:0] de;
  logic signed [49:0] mp [4];

  always_comb begin
    dk = row[DERIV_BITS*node +: DERIV_BITS];
    de = row[DERIV_BITS*(32'(node) + 4) +: DERIV_BITS];
    mp[0] = dk * xs[node];
    mp[1] = de * xs[node];
    mp[2] = dk * ys[node];
    mp[3] = de * ys[node];
  end

  for (genvar k = 0; k < 4; k++) begin : g_acc
    logic signed [65:0] rnd;
    assign rnd = ($signed({{14{acc[k][51]}}, acc[k]}) + 66'sd32768) >>> FRAC_BITS;

    always_ff @(posedge clk) begin
      if (state == ST_READ) begin
        acc[k] <= '0;
      end else if (state == ST_MAC) begin
        acc[k] <= acc[k] + {{2{mp[k][49]}}, mp[k]};
      end
      if (state == ST_ROUND) begin
        jac[k] <= sat32(rnd);
      end
    end
  end

  // determinant: products registered, then difference rounded
  logic signed [65:0] dfull;
  logic signed [65:0] drnd;
  assign dfull = {{2{prod0[63]}}, prod0} - {{2{prod1[63]}}, prod1};
  assign drnd  = (dfull + 66'sd32768) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (state == ST_DMUL) begin
      prod0 <= jac[0] * jac[3];
      prod1 <= jac[1] * jac[2];
    end
    if (state == ST_DSUB) begin
      det      <= sat32(drnd);
      singular <= (sat32(drnd) == 32'sd0);
    end
  end

  assign div_num[0] = {jac[3][31], jac[3]};
  assign div_num[1] = -{jac[1][31], jac[1]};
  assign div_num[2] = -{jac[2][31], jac[2]};
  assign div_num[3] = {jac[0][31], jac[0]};

  qej_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_kick && !singular && !div_start),
    .den   (det),
    .num   (div_num),
    .quo   (div_quo),
    .done  (div_done)
  );

  // result word, valid while the sequencer sits in the output state
  always_comb begin
    out_word.jac_00       = jac[0];
    out_word.jac_01       = jac[1];
    out_word.jac_10       = jac[2];
    out_word.jac_11       = jac[3];
    out_word.determinant  = det;
    out_word.inv_00       = singular ? 32'sd0 : div_quo[0];
    out_word.inv_01       = singular ? 32'sd0 : div_quo[1];
    out_word.inv_10       = singular ? 32'sd0 : div_quo[2];
    out_word.inv_11       = singular ? 32'sd0 : div_quo[3];
    out_word.result_point = point;
    out_word.last_point   = (point == last_idx);
    out_word.singular     = singular;
  end

endmodule
